FILE: design/uft_pkg.sv
// Shared types and constants for the unit format transcoder.
`timescale 1ns / 1ps
`default_nettype none
package uft_pkg;

   localparam int QueueDepth = 4;
   localparam int LitSlots   = 4;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_COMMA = 8'h2C;
   localparam logic [16:0] RECIP_TEN  = 17'd52429;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [7:0] UNIT_TYPE0 = 8'h00;
   localparam logic [7:0] UNIT_TYPE1 = 8'h01;

   typedef enum logic [2:0] {
      PH_TYPE, PH_T0_COUNT, PH_T0_HIGH, PH_T0_LOW,
      PH_T1_COUNT, PH_T1_CSKIP, PH_T1_BODY, PH_T1_BSKIP
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_LIT, BK_WAIT, BK_DEC, BK_EOF
   } back_state_type;

   // One accepted byte's worth of output: literal beats, then an optional
   // decimal number, then an optional end-of-stream beat.
   typedef struct packed {
      logic [LitSlots-1:0][7:0] lit_byte;
      logic [LitSlots-1:0][1:0] lit_kind;
      logic [2:0]               lit_n;
      logic                     has_dec;
      logic [15:0]              dec_val;
      logic                     dec_min3;
      logic                     has_eof;
   } job_type;

endpackage
`default_nettype wire

FILE: design/uft_if.sv
// Channel interfaces for the request, response and control write ports.
`timescale 1ns / 1ps
`default_nettype none
interface uft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_file;
   modport source (output valid, input ready, output in_byte, output end_of_file);
   modport sink   (input valid, output ready, input in_byte, input end_of_file);
endinterface

interface uft_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       last_of_run;
   modport source (output valid, input ready, output out_byte, output kind,
                   output last_of_run);
   modport sink   (input valid, output ready, input out_byte, input kind,
                   input last_of_run);
endinterface

interface uft_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] output_mode;
   modport source (output valid, input ready, output output_mode);
   modport sink   (input valid, output ready, input output_mode);
endinterface
`default_nettype wire

FILE: design/uft_front.sv
// Front end: parses each input beat and issues an output job descriptor.
`timescale 1ns / 1ps
`default_nettype none
module uft_front (
   input  wire logic            clock,
   input  wire logic            reset,
   uft_req_if.sink              req_bus,
   input  wire logic [1:0]      mode,
   input  wire logic            q_full,
   output logic                 q_push,
   output uft_pkg::job_type     q_job
);
   import uft_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  numbers_ff, numbers_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  count_ff, count_in;
   logic [1:0]  cds_ff, cds_in;
   logic [7:0]  commas_ff, commas_in;
   logic [15:0] num_ff, num_in;
   logic        seg_ff, seg_in;
   logic        first_ff, first_in;
   logic        failed_ff, failed_in;
   logic        accept;
   job_type     job;

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign q_job  = job;
   assign q_push = accept && (job.lit_n != 3'd0 || job.has_dec || job.has_eof);

   always_comb begin
      logic [7:0] b;
      logic       c0;
      logic       c1;
      logic       dig;
      logic [7:0] diff;
      b    = req_bus.in_byte;
      c0   = mode[0];
      c1   = mode[1];
      dig  = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
      diff = b - ASCII_ZERO;
      phase_in   = phase_ff;
      numbers_in = numbers_ff;
      high_in    = high_ff;
      count_in   = count_ff;
      cds_in     = cds_ff;
      commas_in  = commas_ff;
      num_in     = num_ff;
      seg_in     = seg_ff;
      first_in   = first_ff;
      failed_in  = failed_ff;
      job        = '0;
      if (failed_ff) begin
         if (req_bus.end_of_file) begin
            failed_in = 1'b0;
            phase_in  = PH_TYPE;
         end
      end else begin
         // close an open text unit when a new unit type byte shows up
         if ((phase_in == PH_T1_BODY || phase_in == PH_T1_BSKIP) &&
             commas_in < 8'd2 && b <= UNIT_TYPE1) begin
            if (c1 && seg_in) begin
               job.lit_byte[job.lit_n[1:0]] = num_in[15:8];
               job.lit_n = job.lit_n + 3'd1;
               job.lit_byte[job.lit_n[1:0]] = num_in[7:0];
               job.lit_n = job.lit_n + 3'd1;
            end
            seg_in   = 1'b0;
            num_in   = '0;
            phase_in = PH_TYPE;
         end
         unique case (phase_in)
            PH_TYPE: begin
               if (b == UNIT_TYPE0) begin
                  job.lit_byte[job.lit_n[1:0]] = c0 ? UNIT_TYPE1 : UNIT_TYPE0;
                  job.lit_n = job.lit_n + 3'd1;
                  phase_in = PH_T0_COUNT;
               end else if (b == UNIT_TYPE1) begin
                  job.lit_byte[job.lit_n[1:0]] = c1 ? UNIT_TYPE0 : UNIT_TYPE1;
                  job.lit_n = job.lit_n + 3'd1;
                  count_in = '0;
                  cds_in   = '0;
                  phase_in = PH_T1_COUNT;
               end else begin
                  failed_in = 1'b1;
                  job.lit_kind[job.lit_n[1:0]] = KIND_ERR;
                  job.lit_n = job.lit_n + 3'd1;
               end
            end
            PH_T0_COUNT: begin
               numbers_in = b;
               first_in   = 1'b1;
               if (c0) begin
                  job.has_dec  = 1'b1;
                  job.dec_val  = {8'd0, b};
                  job.dec_min3 = 1'b1;
               end else begin
                  job.lit_byte[job.lit_n[1:0]] = b;
                  job.lit_n = job.lit_n + 3'd1;
               end
               phase_in = (b != 8'd0) ? PH_T0_HIGH : PH_TYPE;
            end
            PH_T0_HIGH: begin
               high_in = b;
               if (!c0) begin
                  job.lit_byte[job.lit_n[1:0]] = b;
                  job.lit_n = job.lit_n + 3'd1;
               end
               phase_in = PH_T0_LOW;
            end
            PH_T0_LOW: begin
               if (c0) begin
                  if (!first_in) begin
                     job.lit_byte[job.lit_n[1:0]] = ASCII_COMMA;
                     job.lit_n = job.lit_n + 3'd1;
                  end
                  job.has_dec = 1'b1;
                  job.dec_val = {high_in, b};
               end else begin
                  job.lit_byte[job.lit_n[1:0]] = b;
                  job.lit_n = job.lit_n + 3'd1;
               end
               first_in   = 1'b0;
               numbers_in = numbers_in - 8'd1;
               phase_in   = (numbers_in != 8'd0) ? PH_T0_HIGH : PH_TYPE;
            end
            PH_T1_COUNT, PH_T1_CSKIP: begin
               if (!c1) begin
                  job.lit_byte[job.lit_n[1:0]] = b;
                  job.lit_n = job.lit_n + 3'd1;
               end
               if (phase_in == PH_T1_COUNT) begin
                  if (dig)
                     count_in = {count_in[4:0], 3'd0} + {count_in[6:0], 1'b0} +
                                {4'd0, diff[3:0]};
                  else
                     phase_in = PH_T1_CSKIP;
               end
               cds_in = cds_in + 2'd1;
               if (cds_in == 2'd3) begin
                  if (c1) begin
                     job.lit_byte[job.lit_n[1:0]] = count_in;
                     job.lit_n = job.lit_n + 3'd1;
                  end
                  commas_in = count_in;
                  cds_in    = '0;
                  num_in    = '0;
                  seg_in    = 1'b0;
                  phase_in  = PH_T1_BODY;
               end
            end
            PH_T1_BODY, PH_T1_BSKIP: begin
               if (!c1) begin
                  job.lit_byte[job.lit_n[1:0]] = b;
                  job.lit_n = job.lit_n + 3'd1;
               end
               if (b == ASCII_COMMA) begin
                  commas_in = commas_in - 8'd1;
                  if (c1) begin
                     job.lit_byte[job.lit_n[1:0]] = num_in[15:8];
                     job.lit_n = job.lit_n + 3'd1;
                     job.lit_byte[job.lit_n[1:0]] = num_in[7:0];
                     job.lit_n = job.lit_n + 3'd1;
                  end
                  num_in   = '0;
                  seg_in   = 1'b0;
                  phase_in = PH_T1_BODY;
               end else begin
                  seg_in = 1'b1;
                  if (phase_in == PH_T1_BODY && dig)
                     num_in = {num_in[12:0], 3'd0} + {num_in[14:0], 1'b0} +
                              {12'd0, diff[3:0]};
                  else
                     phase_in = PH_T1_BSKIP;
               end
            end
            default: phase_in = PH_TYPE;
         endcase
         if (req_bus.end_of_file) begin
            if (!failed_in) begin
               if ((phase_in == PH_T1_BODY || phase_in == PH_T1_BSKIP) &&
                   c1 && seg_in) begin
                  job.lit_byte[job.lit_n[1:0]] = num_in[15:8];
                  job.lit_n = job.lit_n + 3'd1;
                  job.lit_byte[job.lit_n[1:0]] = num_in[7:0];
                  job.lit_n = job.lit_n + 3'd1;
               end
               job.has_eof = 1'b1;
            end
            failed_in = 1'b0;
            phase_in  = PH_TYPE;
         end
      end
      // end of stream returns the parser to its reset values
      if (req_bus.end_of_file) begin
         numbers_in = '0;
         high_in    = '0;
         count_in   = '0;
         cds_in     = '0;
         commas_in  = '0;
         num_in     = '0;
         seg_in     = 1'b0;
         first_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         numbers_ff <= '0;
         high_ff    <= '0;
         count_ff   <= '0;
         cds_ff     <= '0;
         commas_ff  <= '0;
         num_ff     <= '0;
         seg_ff     <= 1'b0;
         first_ff   <= 1'b1;
         failed_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         numbers_ff <= numbers_in;
         high_ff    <= high_in;
         count_ff   <= count_in;
         cds_ff     <= cds_in;
         commas_ff  <= commas_in;
         num_ff     <= num_in;
         seg_ff     <= seg_in;
         first_ff   <= first_in;
         failed_ff  <= failed_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/uft_queue.sv
// Small job queue between the parser and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module uft_queue #(
   parameter int DEPTH = uft_pkg::QueueDepth
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire uft_pkg::job_type push_job,
   output logic                 full,
   input  wire logic            pop,
   output logic                 empty,
   output uft_pkg::job_type     pop_job
);
   import uft_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type           mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == CntW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign pop_job = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ff + PtrW'(1);
      end
      if (push && !pop)
         cnt_in = cnt_ff + CntW'(1);
      else if (pop && !push)
         cnt_in = cnt_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ff] <= push_job;
   end
endmodule
`default_nettype wire

FILE: design/uft_back.sv
// Back end: expands job descriptors into response beats, with decimal conversion.
`timescale 1ns / 1ps
`default_nettype none
module uft_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire uft_pkg::job_type q_job,
   output logic                  q_pop,
   uft_rsp_if.source             rsp_bus
);
   import uft_pkg::*;

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   logic [2:0]       idx_ff, idx_in;
   logic [15:0]      val_ff, val_in;
   logic [4:0][3:0]  digits_ff, digits_in;
   logic [2:0]       conv_ff, conv_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic [1:0]       kind_ff, kind_in;
   logic             last_ff, last_in;
   logic             can_emit;
   logic [31:0]      prod;
   logic [15:0]      quot;
   logic [15:0]      rem;

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.out_byte    = byte_ff;
   assign rsp_bus.kind        = kind_ff;
   assign rsp_bus.last_of_run = last_ff;
   assign can_emit = !valid_ff || rsp_bus.ready;

   // divide by ten through the reciprocal, one digit per cycle
   assign prod = val_ff * RECIP_TEN[15:0];
   assign quot = {3'd0, prod[31:19]};
   assign rem  = val_ff - ({quot[12:0], 3'd0} + {quot[14:0], 1'b0});

   function automatic logic [2:0] top_digit(logic [4:0][3:0] d, logic min3);
      logic [2:0] n;
      if (d[4] != 4'd0)      n = 3'd5;
      else if (d[3] != 4'd0) n = 3'd4;
      else if (d[2] != 4'd0) n = 3'd3;
      else if (d[1] != 4'd0) n = 3'd2;
      else                   n = 3'd1;
      if (min3 && n < 3'd3)
         n = 3'd3;
      return n - 3'd1;
   endfunction

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      idx_in    = idx_ff;
      val_in    = val_ff;
      digits_in = digits_ff;
      conv_in   = conv_ff;
      valid_in  = valid_ff && !rsp_bus.ready;
      byte_in   = byte_ff;
      kind_in   = kind_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      if (conv_ff != 3'd0) begin
         digits_in = {rem[3:0], digits_ff[4:1]};
         val_in    = quot;
         conv_in   = conv_ff - 3'd1;
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               job_in  = q_job;
               idx_in  = '0;
               val_in  = q_job.dec_val;
               conv_in = q_job.has_dec ? 3'd5 : 3'd0;
               if (q_job.lit_n != 3'd0)  state_in = BK_LIT;
               else if (q_job.has_dec)   state_in = BK_WAIT;
               else                      state_in = BK_EOF;
            end
         end
         BK_LIT: begin
            if (can_emit) begin
               valid_in = 1'b1;
               byte_in  = job_ff.lit_byte[idx_ff[1:0]];
               kind_in  = job_ff.lit_kind[idx_ff[1:0]];
               last_in  = (idx_ff == job_ff.lit_n - 3'd1) && !job_ff.has_dec &&
                          !job_ff.has_eof;
               if (idx_ff == job_ff.lit_n - 3'd1) begin
                  if (job_ff.has_dec)      state_in = BK_WAIT;
                  else if (job_ff.has_eof) state_in = BK_EOF;
                  else                     state_in = BK_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         BK_WAIT: begin
            if (conv_ff == 3'd0) begin
               idx_in   = top_digit(digits_ff, job_ff.dec_min3);
               state_in = BK_DEC;
            end
         end
         BK_DEC: begin
            if (can_emit) begin
               valid_in = 1'b1;
               byte_in  = ASCII_ZERO + {4'd0, digits_ff[idx_ff]};
               kind_in  = KIND_DATA;
               last_in  = (idx_ff == 3'd0) && !job_ff.has_eof;
               if (idx_ff == 3'd0)
                  state_in = job_ff.has_eof ? BK_EOF : BK_IDLE;
               else
                  idx_in = idx_ff - 3'd1;
            end
         end
         BK_EOF: begin
            if (can_emit) begin
               valid_in = 1'b1;
               byte_in  = 8'd0;
               kind_in  = KIND_DONE;
               last_in  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         conv_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         conv_ff  <= conv_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      digits_ff <= digits_in;
      byte_ff   <= byte_in;
      kind_ff   <= kind_in;
      last_ff   <= last_in;
   end
endmodule
`default_nettype wire

FILE: design/unit_format_transcoder_top.sv
// Top level of the unit format transcoder: parser, job queue and output sequencer.
// Usage:
//  req_bus carries one source byte per beat plus an end_of_file flag; rsp_bus
//  returns converted bytes one per beat, with kind 0 for data, 1 when the
//  stream finished, 2 for an unknown unit type. last_of_run marks the final
//  response beat caused by one request beat; a request beat may cause none.
//  csr_bus writes output_mode (bit0 binary-to-text, bit1 text-to-binary);
//  write it only while no request is in flight.
//  The parser takes one request beat per cycle while the job queue has room.
//  The sequencer emits one response beat per cycle while rsp_bus.ready holds;
//  it loads each job from the queue first, and a decimal number goes through
//  five divide-by-ten steps through the reciprocal multiplier and a step that
//  picks the leading digit before its digits go out. Sustained throughput is
//  therefore set by the sequencer, which finishes one job before it loads the
//  next.
//  A response passes the job queue, the sequencer state and its output register.
//  Reset (synchronous, active high) empties the queue, drops any pending
//  response and returns the parser and output_mode to their start values.
//  When the receiver stalls, the response beat holds, the queue fills, and
//  req_bus.ready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
module unit_format_transcoder_top #(
   parameter int QUEUE_DEPTH = uft_pkg::QueueDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   uft_req_if.sink   req_bus,
   uft_rsp_if.source rsp_bus,
   uft_csr_if.sink   csr_bus
);
   import uft_pkg::*;

   logic [1:0] mode_ff;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_empty;
   job_type    push_job;
   job_type    pop_job;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         mode_ff <= '0;
      else if (csr_bus.valid)
         mode_ff <= csr_bus.output_mode;
   end

   uft_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .mode    (mode_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_job   (push_job)
   );

   uft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   uft_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_job   (pop_job),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full)) else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty)) else $error("job popped from empty queue");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_ERR) |-> rsp_bus.last_of_run)
      else $error("error beat not last of run");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_DONE) |-> rsp_bus.last_of_run)
      else $error("done beat not last of run");
`endif
endmodule
`default_nettype wire
